// File: src/mssd_pkg.sv
// ---------------------------------------------------------------------------
// Motion step and shake detector package
// Shared types, codes and constants for the detector core and its parts.
// ---------------------------------------------------------------------------
package mssd_pkg;

    // Operation codes as they arrive on the input stream.
    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_TAKE_STEPS = 2'd1;
    localparam logic [1:0] OP_TAKE_SHAKE = 2'd2;

    // Item kinds after classification by the front end.
    localparam logic [1:0] KIND_SAMPLE     = 2'd0;
    localparam logic [1:0] KIND_TAKE_STEPS = 2'd1;
    localparam logic [1:0] KIND_TAKE_SHAKE = 2'd2;
    localparam logic [1:0] KIND_NONE       = 2'd3;

    // Configuration register indexes.
    localparam logic [3:0] REG_MIN_INTERVAL = 4'd0;
    localparam logic [3:0] REG_BOOT_QUIET   = 4'd1;
    localparam logic [3:0] REG_SHAKE_ACCEL  = 4'd2;
    localparam logic [3:0] REG_SHAKE_GYRO   = 4'd3;

    // Timing constants in milliseconds, then the step bank and peak run count limits.
    localparam logic [15:0] MIN_INTERVAL_FLOOR = 16'd25;
    localparam logic [31:0] GAP_MIN_MS         = 32'd280;
    localparam logic [31:0] GAP_MAX_MS         = 32'd1400;
    localparam logic [31:0] SHAKE_LOCK_MS      = 32'd280;
    localparam logic [16:0] BANK_LIMIT         = 17'd60000;
    localparam logic [7:0]  CADENCE_MAX        = 8'd255;

    // Thresholds in Q4.28 g (Q4.12 values shifted up by 16).
    localparam logic [31:0] TH_EMPTY   = 32'd41 << 16;
    localparam logic [32:0] TH_CALM    = 33'd328 << 16;
    localparam logic [32:0] TH_RELEASE = 33'd102 << 16;
    localparam logic [32:0] TH_PEAK    = 33'd348 << 16;

    // Smoothing weights in Q0.16.
    localparam logic [12:0] W_FAST = 13'd7864;
    localparam logic [12:0] W_SLOW = 13'd1638;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_MIN_INTERVAL = 16'd25;
    localparam logic [31:0] RST_BOOT_QUIET   = 32'd400;
    localparam logic [15:0] RST_SHAKE_ACCEL  = 16'd5939;
    localparam logic [13:0] RST_SHAKE_GYRO   = 14'd1280;

    // One classified input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_ms;
        logic        accel_valid;
        logic [15:0] accel_mag;
        logic        gyro_valid;
        logic [13:0] gyro_mag;
    } item_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] min_interval_ms;
        logic [31:0] boot_quiet_until_ms;
        logic [15:0] shake_accel_level;
        logic [13:0] shake_gyro_level;
    } cfg_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // A deadline is active while it lies less than half the time range ahead.
    function automatic logic deadline_active(input logic [31:0] now,
                                             input logic [31:0] deadline);
        logic [31:0] d;
        begin
            d = deadline - now;
            deadline_active = (d != 32'd0) && !d[31];
        end
    endfunction

endpackage

// File: src/mssd_front.sv
// ---------------------------------------------------------------------------
// Motion step and shake detector front end
// Accepts input transactions, classifies the operation and hands the item
// to the queue.
// ---------------------------------------------------------------------------
module mssd_front
    import mssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  q_status_t   q_status,
    output logic        push,
    output item_t       push_item
);

    logic  hold_valid_reg;
    item_t hold_item_reg;
    item_t in_item;
    logic  accept;

    // Unpack the stream payload and classify the operation.
    always_comb
    begin
        in_item.time_ms     = s_axis_tdata[31:0];
        in_item.accel_valid = s_axis_tdata[32];
        in_item.accel_mag   = s_axis_tdata[48:33];
        in_item.gyro_valid  = s_axis_tdata[49];
        in_item.gyro_mag    = s_axis_tdata[63:50];
        case (s_axis_tuser)
            OP_SAMPLE:     in_item.kind = KIND_SAMPLE;
            OP_TAKE_STEPS: in_item.kind = KIND_TAKE_STEPS;
            OP_TAKE_SHAKE: in_item.kind = KIND_TAKE_SHAKE;
            default:       in_item.kind = KIND_NONE;
        endcase
    end

    // The holding register drains into the queue whenever there is room.
    assign push          = hold_valid_reg && !q_status.full;
    assign s_axis_tready = !hold_valid_reg || !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_item     = hold_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= in_item;
        end
    end

endmodule

// File: src/mssd_queue.sv
// ---------------------------------------------------------------------------
// Motion step and shake detector item queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module mssd_queue
    import mssd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head_item,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_item      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/mssd_back.sv
// ---------------------------------------------------------------------------
// Motion step and shake detector back end
// Carries out queued items: interval check, gravity baseline, peak and
// cadence tracking, step bank, shake flag, and the output register.
// ---------------------------------------------------------------------------
module mssd_back
    import mssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  q_status_t   q_status,
    input  item_t       head_item,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    item_t       item_reg;

    // Detector state.
    logic [31:0] last_sample_time_reg;
    logic [31:0] last_sample_time_next;
    logic [31:0] gravity_baseline_reg;
    logic [31:0] gravity_baseline_next;
    logic        peak_active_reg;
    logic        peak_active_next;
    logic [31:0] last_peak_time_reg;
    logic [31:0] last_peak_time_next;
    logic [7:0]  cadence_count_reg;
    logic [7:0]  cadence_count_next;
    logic [15:0] step_bank_reg;
    logic [15:0] step_bank_next;
    logic [31:0] step_sum_reg;
    logic [31:0] step_sum_next;
    logic        shake_pending_reg;
    logic        shake_pending_next;
    logic [31:0] shake_lock_until_reg;
    logic [31:0] shake_lock_until_next;
    logic [15:0] held_accel_mag_reg;
    logic [15:0] held_accel_mag_next;
    logic [13:0] held_gyro_mag_reg;
    logic [13:0] held_gyro_mag_next;

    // Per-item working registers.
    logic signed [32:0] signal_reg;
    logic signed [32:0] signal_next;
    logic [12:0]        weight_reg;
    logic [12:0]        weight_next;
    logic signed [46:0] prod_reg;
    logic signed [46:0] prod_next;
    logic               quiet_reg;
    logic               quiet_next;
    logic               accepted_reg;
    logic               accepted_next;
    logic [15:0]        taken_reg;
    logic [15:0]        taken_next;
    logic               shake_reg;
    logic               shake_next;

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [55:0] out_data_reg;
    logic [55:0] out_data_next;

    // Helper terms.
    logic               out_free;
    logic [15:0]        interval;
    logic               interval_ok;
    logic [32:0]        mag28;
    logic [32:0]        motion;
    logic               hot;
    logic signed [46:0] prod_bias;
    logic signed [30:0] quotient;
    logic [31:0]        gap;
    logic [16:0]        bank_sum;
    logic [1:0]         add_n;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Interval check against the floored minimum spacing.
    assign interval    = (cfg.min_interval_ms < MIN_INTERVAL_FLOOR) ?
                         MIN_INTERVAL_FLOOR : cfg.min_interval_ms;
    assign interval_ok = (last_sample_time_reg == 32'd0) ||
                         ((item_reg.time_ms - last_sample_time_reg) >= {16'd0, interval});

    // Deviation of the sample from the baseline, in Q4.28.
    assign mag28  = {1'b0, item_reg.accel_mag, 16'd0};
    assign motion = signal_next[32] ? 33'(-signal_next) : 33'(signal_next);

    // Baseline step, truncated toward zero.
    assign prod_bias = prod_reg[46] ? (prod_reg + 47'sd65535) : prod_reg;
    assign quotient  = 31'(prod_bias >>> 16);

    assign gap = item_reg.time_ms - last_peak_time_reg;

    always_comb
    begin
        state_next            = state_reg;
        pop                   = 1'b0;
        last_sample_time_next = last_sample_time_reg;
        gravity_baseline_next = gravity_baseline_reg;
        peak_active_next      = peak_active_reg;
        last_peak_time_next   = last_peak_time_reg;
        cadence_count_next    = cadence_count_reg;
        step_bank_next        = step_bank_reg;
        step_sum_next         = step_sum_reg;
        shake_pending_next    = shake_pending_reg;
        shake_lock_until_next = shake_lock_until_reg;
        held_accel_mag_next   = held_accel_mag_reg;
        held_gyro_mag_next    = held_gyro_mag_reg;
        signal_next           = 33'(mag28) - $signed({1'b0, gravity_baseline_reg});
        weight_next           = weight_reg;
        prod_next             = $signed(signal_reg) * $signed({1'b0, weight_reg});
        quiet_next            = quiet_reg;
        accepted_next         = accepted_reg;
        taken_next            = taken_reg;
        shake_next            = shake_reg;
        out_valid_next        = out_valid_reg && !m_axis_tready;
        out_data_next         = out_data_reg;
        hot                   = 1'b0;
        add_n                 = 2'd0;
        bank_sum              = 17'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            // Interval check, held readings, shake flag and take requests.
            ST_EVAL:
            begin
                accepted_next = 1'b0;
                taken_next    = 16'd0;
                shake_next    = 1'b0;
                quiet_next    = deadline_active(item_reg.time_ms, cfg.boot_quiet_until_ms);
                state_next    = ST_DONE;
                weight_next   = (motion < TH_CALM) ? W_FAST : W_SLOW;
                case (item_reg.kind)
                    KIND_SAMPLE:
                    begin
                        if (interval_ok)
                        begin
                            accepted_next         = 1'b1;
                            last_sample_time_next = (item_reg.time_ms != 32'd0) ?
                                                    item_reg.time_ms : 32'd1;
                            if (item_reg.accel_valid)
                            begin
                                held_accel_mag_next = item_reg.accel_mag;
                                if (gravity_baseline_reg <= TH_EMPTY)
                                begin
                                    gravity_baseline_next = mag28[31:0];
                                end
                                else
                                begin
                                    state_next = ST_MUL;
                                end
                            end
                            if (item_reg.gyro_valid)
                            begin
                                held_gyro_mag_next = item_reg.gyro_mag;
                            end
                            hot = (held_accel_mag_next >= cfg.shake_accel_level) ||
                                  (held_gyro_mag_next >= cfg.shake_gyro_level);
                            if (!quiet_next && hot &&
                                !deadline_active(item_reg.time_ms, shake_lock_until_reg))
                            begin
                                shake_pending_next    = 1'b1;
                                shake_lock_until_next = item_reg.time_ms + SHAKE_LOCK_MS;
                            end
                        end
                    end
                    KIND_TAKE_STEPS:
                    begin
                        taken_next     = step_bank_reg;
                        step_bank_next = 16'd0;
                    end
                    KIND_TAKE_SHAKE:
                    begin
                        shake_next         = shake_pending_reg;
                        shake_pending_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Weighted deviation for the baseline filter.
            ST_MUL:
            begin
                state_next = ST_UPD;
            end

            // Baseline update, then peak and cadence tracking and the step bank and total.
            ST_UPD:
            begin
                gravity_baseline_next = gravity_baseline_reg +
                                        {{1{quotient[30]}}, 31'(quotient)};
                state_next = ST_DONE;
                if (!quiet_reg)
                begin
                    if (peak_active_reg)
                    begin
                        if (signal_reg <= $signed(TH_RELEASE))
                        begin
                            peak_active_next = 1'b0;
                        end
                    end
                    else if (signal_reg >= $signed(TH_PEAK))
                    begin
                        peak_active_next = 1'b1;
                        if (last_peak_time_reg == 32'd0 || gap > GAP_MAX_MS)
                        begin
                            last_peak_time_next = item_reg.time_ms;
                            cadence_count_next  = 8'd1;
                        end
                        else if (gap >= GAP_MIN_MS)
                        begin
                            last_peak_time_next = item_reg.time_ms;
                            if (cadence_count_reg == 8'd1)
                            begin
                                add_n              = 2'd2;
                                cadence_count_next = 8'd2;
                            end
                            else
                            begin
                                add_n = 2'd1;
                                if (cadence_count_reg < CADENCE_MAX)
                                begin
                                    cadence_count_next = cadence_count_reg + 8'd1;
                                end
                            end
                        end
                    end
                end
                bank_sum       = {1'b0, step_bank_reg} + {15'd0, add_n};
                step_bank_next = (bank_sum > BANK_LIMIT) ? BANK_LIMIT[15:0] : bank_sum[15:0];
                step_sum_next  = step_sum_reg + {30'd0, add_n};
            end

            // Hand the result to the output register once it is free and start the next item if one is queued.
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, step_sum_reg, shake_reg, taken_reg,
                                      accepted_reg};
                    if (!q_status.empty)
                    begin
                        pop        = 1'b1;
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and detector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            last_sample_time_reg <= 32'd0;
            gravity_baseline_reg <= 32'd0;
            peak_active_reg      <= 1'b0;
            last_peak_time_reg   <= 32'd0;
            cadence_count_reg    <= 8'd0;
            step_bank_reg        <= 16'd0;
            step_sum_reg         <= 32'd0;
            shake_pending_reg    <= 1'b0;
            shake_lock_until_reg <= 32'd0;
            held_accel_mag_reg   <= 16'd0;
            held_gyro_mag_reg    <= 14'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            last_sample_time_reg <= last_sample_time_next;
            gravity_baseline_reg <= gravity_baseline_next;
            peak_active_reg      <= peak_active_next;
            last_peak_time_reg   <= last_peak_time_next;
            cadence_count_reg    <= cadence_count_next;
            step_bank_reg        <= step_bank_next;
            step_sum_reg         <= step_sum_next;
            shake_pending_reg    <= shake_pending_next;
            shake_lock_until_reg <= shake_lock_until_next;
            held_accel_mag_reg   <= held_accel_mag_next;
            held_gyro_mag_reg    <= held_gyro_mag_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
        if (state_reg == ST_EVAL)
        begin
            signal_reg <= signal_next;
        end
        weight_reg   <= weight_next;
        prod_reg     <= prod_next;
        quiet_reg    <= quiet_next;
        accepted_reg <= accepted_next;
        taken_reg    <= taken_next;
        shake_reg    <= shake_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: src/motion_step_and_shake_detector_core.sv
// ---------------------------------------------------------------------------
// Motion step and shake detector core
// Each item passes the front end holding register and the queue, then the
// back end sequencer's evaluate and done states; a motion sample that
// reaches the baseline filter also passes its multiply and update states.
// The back end starts the next item only once the last result is in the output
// register, and waits while the output register holds a result not yet taken.
// Reset: asynchronous and active low; control state, detector state and
// configuration return to their defaults at once, with no clearing pass.
// ---------------------------------------------------------------------------
module motion_step_and_shake_detector_core
    import mssd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: time_ms[31:0], accel_valid[32], accel_mag[48:33],
    //        gyro_valid[49], gyro_mag[63:50]
    input  logic [63:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: sample_accepted[0], steps_taken[16:1], shake_event[17],
    //        step_total[49:18], zero fill[55:50]
    output logic [55:0] m_axis_tdata,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      push;
    item_t     push_item;
    logic      pop;
    item_t     head_item;

    // Configuration registers; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval_ms     <= RST_MIN_INTERVAL;
            cfg_reg.boot_quiet_until_ms <= RST_BOOT_QUIET;
            cfg_reg.shake_accel_level   <= RST_SHAKE_ACCEL;
            cfg_reg.shake_gyro_level    <= RST_SHAKE_GYRO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_INTERVAL: cfg_reg.min_interval_ms     <= cfg_data[15:0];
                REG_BOOT_QUIET:   cfg_reg.boot_quiet_until_ms <= cfg_data;
                REG_SHAKE_ACCEL:  cfg_reg.shake_accel_level   <= cfg_data[15:0];
                REG_SHAKE_GYRO:   cfg_reg.shake_gyro_level    <= cfg_data[13:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: accept and classify.
    mssd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    // Queue between the two halves.
    mssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // Back end: execute and deliver results.
    mssd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
